// File: rtl/core/psn_pkg.sv
// psn_pkg: shared types, widths and codes for the point to segment nearest block
// no dependencies
package psn_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // divider row: 33 quotient bits, one per cell
    localparam int QW      = 33;
    localparam int FOOT_W  = 100;   // 2*|d|*t + l2 < 2^99
    localparam int DIST_W  = 97;    // |cross| * 2^31 < 2^97
    localparam int L2_W    = 66;
    localparam int ROOT_W  = 64;
    localparam int RAD_W   = 128;   // l2 * 2^62

    localparam logic [1:0] END_NONE   = 2'd0;
    localparam logic [1:0] END_FIRST  = 2'd1;
    localparam logic [1:0] END_SECOND = 2'd2;

    localparam logic [1:0] REG_SX = 2'd0;
    localparam logic [1:0] REG_SY = 2'd1;
    localparam logic [1:0] REG_EX = 2'd2;
    localparam logic [1:0] REG_EY = 2'd3;

    typedef enum logic [2:0] {
        CF_DIFF,
        CF_SQ,
        CF_SUM,
        CF_ROOT,
        CF_READY
    } cf_state_t;

    typedef enum logic {
        SQ_IDLE,
        SQ_RUN
    } sq_state_t;

    // per-beat control that rides alongside the divider row
    typedef struct packed {
        logic       vld;
        logic [1:0] taken;
        logic       behind;
        logic       sat;
    } side_t;

endpackage

// File: rtl/core/point_segment_nearest_top.sv
// point_segment_nearest_top: nearest point on a configured segment for each query beat
// depends on psn_pkg, psn_div_cell, psn_isqrt
// pipeline: 5 front stages, 33 divider cells and an output register from input beat to output beat
// throughput: one beat per cycle; the whole pipe holds while the output beat is not taken
// after reset and after every configuration write the segment length root is rebuilt
// by the bit-pair square root, during which s_tready stays low
// reset: asynchronous active low, segment (0,0)-(1<<FRAC_BITS,0), pipe empty
module point_segment_nearest_top #(
    parameter int FRAC_BITS = psn_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,    // query_x, query_y
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata,    // near_x, near_y, line_distance, behind_side, zero pad
    output logic [2:0]    m_tuser,    // end_taken, degenerate
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data
);

    localparam int QW = psn_pkg::QW;
    localparam int FW = psn_pkg::FOOT_W;
    localparam int DW = psn_pkg::DIST_W;

    // configuration and derived segment constants
    logic signed [31:0]           sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [32:0]           dx_reg, dy_reg;
    logic [65:0]                  dxsq_reg, dysq_reg;
    logic [psn_pkg::L2_W-1:0]     l2_reg;
    logic [psn_pkg::L2_W-1:0]     l2_sum;
    psn_pkg::cf_state_t           cf_state_reg, cf_state_next;
    logic                         sq_start;
    logic                         sq_done;
    logic [psn_pkg::ROOT_W-1:0]   root;
    logic [32:0]                  dx_mag, dy_mag;
    logic                         degen;
    logic                         cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg <= '0;
            sy_reg <= '0;
            ex_reg <= 32'(64'(1) << FRAC_BITS);
            ey_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                psn_pkg::REG_SX: sx_reg <= cfg_data;
                psn_pkg::REG_SY: sy_reg <= cfg_data;
                psn_pkg::REG_EX: ex_reg <= cfg_data;
                psn_pkg::REG_EY: ey_reg <= cfg_data;
                default:         sx_reg <= sx_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cf_state_reg <= psn_pkg::CF_DIFF;
        else
            cf_state_reg <= cf_state_next;
    end

    always_comb
    begin
        cf_state_next = cf_state_reg;
        sq_start      = 1'b0;
        unique case (cf_state_reg)
            psn_pkg::CF_DIFF:  cf_state_next = psn_pkg::CF_SQ;
            psn_pkg::CF_SQ:    cf_state_next = psn_pkg::CF_SUM;
            psn_pkg::CF_SUM:   cf_state_next = psn_pkg::CF_ROOT;
            psn_pkg::CF_ROOT:
            begin
                if (sq_done)
                    cf_state_next = psn_pkg::CF_READY;
            end
            psn_pkg::CF_READY: cf_state_next = psn_pkg::CF_READY;
            default:           cf_state_next = psn_pkg::CF_DIFF;
        endcase
        if (cf_state_reg == psn_pkg::CF_SUM)
            sq_start = 1'b1;
        if (cfg_wr)
            cf_state_next = psn_pkg::CF_DIFF;
    end

    assign l2_sum = dxsq_reg + dysq_reg;

    always_ff @(posedge clk)
    begin
        if (cf_state_reg == psn_pkg::CF_DIFF)
        begin
            dx_reg <= 33'(ex_reg) - 33'(sx_reg);
            dy_reg <= 33'(ey_reg) - 33'(sy_reg);
        end
        if (cf_state_reg == psn_pkg::CF_SQ)
        begin
            dxsq_reg <= dx_mag * dx_mag;
            dysq_reg <= dy_mag * dy_mag;
        end
        if (cf_state_reg == psn_pkg::CF_SUM)
            l2_reg <= l2_sum;
    end

    assign dx_mag = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
    assign dy_mag = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
    assign degen  = (dx_reg == '0) && (dy_reg == '0);

    // the root loads the sum directly, l2_reg is written on the same edge
    psn_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .l2    (l2_sum),
        .root  (root),
        .done  (sq_done)
    );

    // pipe advance: everything moves when the output register is free or drained
    logic en;
    logic m_tvalid_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en && (cf_state_reg == psn_pkg::CF_READY);

    // stage 0: offsets from the endpoints
    logic               v0_reg;
    logic signed [32:0] qx_reg, qy_reg;
    logic signed [33:0] mx_reg, my_reg;
    logic signed [31:0] px, py;

    assign px = s_tdata[31:0];
    assign py = s_tdata[63:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= s_tvalid && s_tready;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_reg <= 33'(px) - 33'(sx_reg);
            qy_reg <= 33'(py) - 33'(sy_reg);
            mx_reg <= (34'(px) <<< 1) - 34'(sx_reg) - 34'(ex_reg);
            my_reg <= (34'(py) <<< 1) - 34'(sy_reg) - 34'(ey_reg);
        end
    end

    // stage 1: products
    logic               v1_reg;
    logic signed [67:0] p_qxdx_reg, p_qydy_reg, p_dxqy_reg, p_dyqx_reg;
    logic signed [67:0] p_dxmy_reg, p_dymx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_qxdx_reg <= qx_reg * dx_reg;
            p_qydy_reg <= qy_reg * dy_reg;
            p_dxqy_reg <= dx_reg * qy_reg;
            p_dyqx_reg <= dy_reg * qx_reg;
            p_dxmy_reg <= dx_reg * my_reg;
            p_dymx_reg <= dy_reg * mx_reg;
        end
    end

    // stage 2: projection, cross and side sums, endpoint decision
    logic               v2_reg;
    logic signed [67:0] t_s, cr_s, side_s;
    logic [1:0]         taken2, taken2_reg;
    logic [65:0]        t2_reg;
    logic [65:0]        crmag2_reg;
    logic               behind2_reg;

    assign t_s    = p_qxdx_reg + p_qydy_reg;
    assign cr_s   = p_dxqy_reg - p_dyqx_reg;
    assign side_s = p_dxmy_reg - p_dymx_reg;

    always_comb
    begin
        priority if (t_s <= 68'sd0)
            taken2 = psn_pkg::END_FIRST;
        else if (t_s >= $signed({2'b00, l2_reg}))
            taken2 = psn_pkg::END_SECOND;
        else
            taken2 = psn_pkg::END_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            taken2_reg  <= taken2;
            t2_reg      <= t_s[65:0];
            crmag2_reg  <= cr_s[67] ? 66'(-cr_s) : 66'(cr_s);
            behind2_reg <= side_s[67];
        end
    end

    // stage 3: partial products of |d| * t, distance saturation test
    logic               v3_reg;
    logic [65:0]        ppx_lo_reg, ppx_hi_reg, ppy_lo_reg, ppy_hi_reg;
    logic [1:0]         taken3_reg;
    logic [65:0]        crmag3_reg;
    logic               behind3_reg;
    logic               sat3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ppx_lo_reg  <= dx_mag * t2_reg[32:0];
            ppx_hi_reg  <= dx_mag * t2_reg[65:33];
            ppy_lo_reg  <= dy_mag * t2_reg[32:0];
            ppy_hi_reg  <= dy_mag * t2_reg[65:33];
            taken3_reg  <= taken2_reg;
            crmag3_reg  <= crmag2_reg;
            behind3_reg <= behind2_reg;
            // quotient would need more than 33 bits
            sat3_reg    <= crmag2_reg >= {root, 2'b00};
        end
    end

    // stage 4: dividends for the cell row
    psn_pkg::side_t side4_reg;
    logic [FW-1:0]  numx_reg, numy_reg;
    logic [DW-1:0]  numd_reg;
    logic [FW-1:0]  div_foot;
    logic [DW-1:0]  div_dist;

    assign div_foot = FW'({l2_reg, 1'b0});
    assign div_dist = DW'(root);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side4_reg.vld <= 1'b0;
        else if (en)
        begin
            side4_reg.vld    <= v3_reg;
            side4_reg.taken  <= taken3_reg;
            side4_reg.behind <= behind3_reg;
            side4_reg.sat    <= sat3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numx_reg <= ((FW'(ppx_hi_reg) << 33) + FW'(ppx_lo_reg) << 1) + FW'(l2_reg);
            numy_reg <= ((FW'(ppy_hi_reg) << 33) + FW'(ppy_lo_reg) << 1) + FW'(l2_reg);
            numd_reg <= DW'(crmag3_reg) << 31;
        end
    end

    // cell row: cell k settles quotient bit QW-1-k of each of the three divisions
    logic [FW-1:0]  remx [0:QW];
    logic [FW-1:0]  remy [0:QW];
    logic [DW-1:0]  remd [0:QW];
    logic [QW-1:0]  quox [0:QW];
    logic [QW-1:0]  quoy [0:QW];
    logic [QW-1:0]  quod [0:QW];
    psn_pkg::side_t side_reg [1:QW];

    assign remx[0] = numx_reg;
    assign remy[0] = numy_reg;
    assign remd[0] = numd_reg;
    assign quox[0] = '0;
    assign quoy[0] = '0;
    assign quod[0] = '0;

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_row
            psn_div_cell #(.W(FW), .BIT(QW-1-k)) u_cx (
                .clk(clk), .en(en), .divisor(div_foot),
                .rem_in(remx[k]), .quo_in(quox[k]),
                .rem_reg(remx[k+1]), .quo_reg(quox[k+1])
            );
            psn_div_cell #(.W(FW), .BIT(QW-1-k)) u_cy (
                .clk(clk), .en(en), .divisor(div_foot),
                .rem_in(remy[k]), .quo_in(quoy[k]),
                .rem_reg(remy[k+1]), .quo_reg(quoy[k+1])
            );
            psn_div_cell #(.W(DW), .BIT(QW-1-k)) u_cd (
                .clk(clk), .en(en), .divisor(div_dist),
                .rem_in(remd[k]), .quo_in(quod[k]),
                .rem_reg(remd[k+1]), .quo_reg(quod[k+1])
            );

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    side_reg[k+1].vld <= 1'b0;
                else if (en)
                begin
                    if (k == 0)
                    begin
                        side_reg[k+1].vld    <= side4_reg.vld;
                        side_reg[k+1].taken  <= side4_reg.taken;
                        side_reg[k+1].behind <= side4_reg.behind;
                        side_reg[k+1].sat    <= side4_reg.sat;
                    end
                    else
                    begin
                        side_reg[k+1].vld    <= side_reg[k].vld;
                        side_reg[k+1].taken  <= side_reg[k].taken;
                        side_reg[k+1].behind <= side_reg[k].behind;
                        side_reg[k+1].sat    <= side_reg[k].sat;
                    end
                end
            end
        end
    endgenerate

    // output register
    psn_pkg::side_t     sf;
    logic signed [33:0] offx, offy;
    logic signed [33:0] footx, footy;
    logic [31:0]        near_x_next, near_y_next, dist_next;
    logic [1:0]         taken_next;
    logic               behind_next;
    logic [31:0]        near_x_reg, near_y_reg, dist_reg;
    logic [1:0]         taken_reg;
    logic               behind_reg, degen_reg;

    assign sf    = side_reg[QW];
    assign offx  = dx_reg[32] ? -$signed({1'b0, quox[QW]}) : $signed({1'b0, quox[QW]});
    assign offy  = dy_reg[32] ? -$signed({1'b0, quoy[QW]}) : $signed({1'b0, quoy[QW]});
    assign footx = 34'(sx_reg) + offx;
    assign footy = 34'(sy_reg) + offy;

    always_comb
    begin
        unique case (sf.taken)
            psn_pkg::END_NONE:
            begin
                near_x_next = footx[31:0];
                near_y_next = footy[31:0];
            end
            psn_pkg::END_SECOND:
            begin
                near_x_next = ex_reg;
                near_y_next = ey_reg;
            end
            default:
            begin
                near_x_next = sx_reg;
                near_y_next = sy_reg;
            end
        endcase
        taken_next  = sf.taken;
        behind_next = sf.behind;
        dist_next   = (sf.sat || quod[QW][QW-1]) ? '1 : quod[QW][31:0];
        if (degen)
        begin
            near_x_next = sx_reg;
            near_y_next = sy_reg;
            taken_next  = psn_pkg::END_FIRST;
            behind_next = 1'b0;
            dist_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (en)
            m_tvalid_reg <= sf.vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            near_x_reg <= near_x_next;
            near_y_reg <= near_y_next;
            dist_reg   <= dist_next;
            taken_reg  <= taken_next;
            behind_reg <= behind_next;
            degen_reg  <= degen;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, behind_reg, dist_reg, near_y_reg, near_x_reg};
    assign m_tuser  = {degen_reg, taken_reg};

    // a degenerate segment always reports the first endpoint with no distance
    a_degen_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == psn_pkg::END_FIRST
            && m_tdata[95:64] == 32'd0 && m_tdata[96] == 1'b0))
        else $error("degenerate beat with wrong fields");

    a_taken_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[1:0] == psn_pkg::END_NONE || m_tuser[1:0] == psn_pkg::END_FIRST
            || m_tuser[1:0] == psn_pkg::END_SECOND))
        else $error("end code out of range");

    // a configuration write must hold off queries while the root is rebuilt
    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> !s_tready)
        else $error("query accepted right after a configuration write");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(side4_reg.vld) && $stable(v3_reg))
        else $error("pipe moved while stalled");

endmodule

// File: rtl/core/psn_div_cell.sv
// psn_div_cell: one restoring division cell, settles one quotient bit per beat
// depends on psn_pkg
module psn_div_cell #(
    parameter int W   = psn_pkg::FOOT_W,
    parameter int BIT = 0
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [W-1:0]               divisor,
    input  logic [W-1:0]               rem_in,
    input  logic [psn_pkg::QW-1:0]     quo_in,
    output logic [W-1:0]               rem_reg,
    output logic [psn_pkg::QW-1:0]     quo_reg
);

    logic [W-1:0]           trial;
    logic [W-1:0]           rem_next;
    logic [psn_pkg::QW-1:0] quo_next;

    assign trial = divisor << BIT;

    always_comb
    begin
        rem_next = rem_in;
        quo_next = quo_in;
        if (rem_in >= trial)
        begin
            rem_next      = rem_in - trial;
            quo_next[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

// File: rtl/core/psn_isqrt.sv
// psn_isqrt: bit-pair integer square root of l2 * 2^62, two radicand bits per cycle
// depends on psn_pkg
module psn_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [psn_pkg::L2_W-1:0]      l2,
    output logic [psn_pkg::ROOT_W-1:0]    root,
    output logic                          done
);

    localparam int RW = psn_pkg::ROOT_W + 4;
    localparam int CW = $clog2(psn_pkg::ROOT_W);

    psn_pkg::sq_state_t              state_reg, state_next;
    logic [psn_pkg::RAD_W-1:0]       rad_reg, rad_next;
    logic [RW-1:0]                   rem_reg, rem_next;
    logic [psn_pkg::ROOT_W-1:0]      root_reg, root_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic [RW-1:0]                   shifted;
    logic [RW-1:0]                   trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psn_pkg::SQ_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign shifted = {rem_reg[RW-3:0], rad_reg[psn_pkg::RAD_W-1 -: 2]};
    assign trial   = {2'b00, root_reg, 2'b01};

    always_comb
    begin
        state_next = state_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        cnt_next   = cnt_reg;
        if (start)
        begin
            state_next = psn_pkg::SQ_RUN;
            rad_next   = {l2, {(psn_pkg::RAD_W - psn_pkg::L2_W){1'b0}}};
            rem_next   = '0;
            root_next  = '0;
            cnt_next   = '1;
        end
        else
        begin
            unique case (state_reg)
                psn_pkg::SQ_RUN:
                begin
                    rad_next = rad_reg << 2;
                    if (shifted >= trial)
                    begin
                        rem_next  = shifted - trial;
                        root_next = {root_reg[psn_pkg::ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next  = shifted;
                        root_next = {root_reg[psn_pkg::ROOT_W-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_next = psn_pkg::SQ_IDLE;
                end
                psn_pkg::SQ_IDLE:
                begin
                end
                default:
                begin
                    state_next = psn_pkg::SQ_IDLE;
                end
            endcase
        end
    end

    assign root = root_reg;
    assign done = (state_reg == psn_pkg::SQ_IDLE) && !start;

endmodule
